// ===== sv/cfs_pkg.sv =====
package cfs_pkg;

	localparam int LIT_W           = 11;
	localparam int LIT_SPACE       = 2048;
	localparam int CFG_W           = 5;
	localparam int CNT_W           = 16;
	localparam int DEF_MAX_LITS    = 16;
	localparam int DEF_MAX_CLAUSES = 1024;
	localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

	typedef enum logic [1:0] {
		OUT_NONE       = 2'd0,
		OUT_SUBSUMED   = 2'd1,
		OUT_STRENGTHEN = 2'd2,
		OUT_TOO_LARGE  = 2'd3
	} outcome_t;

	// controller to datapath
	typedef struct packed {
		logic push;        // take a literal into the current clause
		logic clr_init;    // start a clear sweep, empty the store
		logic clr_step;    // zero one watch count
		logic res_clear;   // result fields to none
		logic too_large;   // result to too large
		logic scan_init;   // first watch literal, first stored clause
		logic adv_watch;   // next watch literal
		logic d_inc;       // next stored clause
		logic tc_init;     // start testing a stored clause
		logic tc_step;     // accept one literal of the stored clause
		logic match;       // record the deciding clause
		logic set_full;    // store has no room
		logic best_init;   // start the watch selection
		logic best_step;   // compare one watch count
		logic wr_step;     // write one literal into the store
		logic strobe;      // present the result
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_done;
		logic too_large;
		logic gt2;
		logic full;
		logic d_end;
		logic watch_last;
		logic watch_hit;
		logic k_end;
		logic tc_fail;
		logic best_done;
		logic wr_done;
	} sts_t;

	function automatic logic [LIT_W-1:0] neg_lit(input logic [LIT_W-1:0] x);
		return LIT_W'(0) - x;
	endfunction

endpackage

// ===== sv/cfs_ctrl.sv =====
module cfs_ctrl import cfs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic op,
	input  logic last,
	input  sts_t sts,
	output cmd_t cmd,
	output logic busy
);

	typedef enum logic [11:0] {
		S_CLR      = 12'b0000_0000_0001,
		S_IDLE     = 12'b0000_0000_0010,
		S_DECIDE   = 12'b0000_0000_0100,
		S_STORE    = 12'b0000_0000_1000,
		S_SW_ADDR  = 12'b0000_0001_0000,
		S_SW_CHK   = 12'b0000_0010_0000,
		S_TC_ADDR  = 12'b0000_0100_0000,
		S_TC_CHK   = 12'b0000_1000_0000,
		S_BST_ADDR = 12'b0001_0000_0000,
		S_BST_CHK  = 12'b0010_0000_0000,
		S_WR       = 12'b0100_0000_0000,
		S_RESULT   = 12'b1000_0000_0000
	} state_t;

	state_t state_q, state_d;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_CLR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					if (op) begin
						cmd.clr_init = 1'b1;
						state_d      = S_CLR;
					end else begin
						cmd.push = 1'b1;
						if (last) state_d = S_DECIDE;
					end
				end
			end
			S_DECIDE: begin
				if (sts.too_large) begin
					cmd.too_large = 1'b1;
					state_d       = S_RESULT;
				end else if (sts.gt2) begin
					cmd.scan_init = 1'b1;
					state_d       = S_SW_ADDR;
				end else begin
					cmd.res_clear = 1'b1;
					state_d       = S_STORE;
				end
			end
			S_STORE: begin
				if (sts.full) begin
					cmd.set_full = 1'b1;
					state_d      = S_RESULT;
				end else begin
					cmd.best_init = 1'b1;
					state_d       = S_BST_ADDR;
				end
			end
			S_SW_ADDR: begin
				if (sts.d_end) begin
					if (sts.watch_last) state_d = S_STORE;
					else cmd.adv_watch = 1'b1;
				end else begin
					state_d = S_SW_CHK;
				end
			end
			S_SW_CHK: begin
				if (sts.watch_hit) begin
					cmd.tc_init = 1'b1;
					state_d     = S_TC_ADDR;
				end else begin
					cmd.d_inc = 1'b1;
					state_d   = S_SW_ADDR;
				end
			end
			S_TC_ADDR: begin
				if (sts.k_end) begin
					cmd.match = 1'b1;
					state_d   = S_STORE;
				end else begin
					state_d = S_TC_CHK;
				end
			end
			S_TC_CHK: begin
				if (sts.tc_fail) begin
					cmd.d_inc = 1'b1;
					state_d   = S_SW_ADDR;
				end else begin
					cmd.tc_step = 1'b1;
					state_d     = S_TC_ADDR;
				end
			end
			S_BST_ADDR: state_d = S_BST_CHK;
			S_BST_CHK: begin
				cmd.best_step = 1'b1;
				state_d       = sts.best_done ? S_WR : S_BST_ADDR;
			end
			S_WR: begin
				cmd.wr_step = 1'b1;
				if (sts.wr_done) state_d = S_RESULT;
			end
			S_RESULT: begin
				cmd.strobe = 1'b1;
				state_d    = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLR;
		else state_q <= state_d;
	end

endmodule

// ===== sv/cfs_dp.sv =====
module cfs_dp import cfs_pkg::*; #(
	parameter int MAX_LITS    = DEF_MAX_LITS,
	parameter int MAX_CLAUSES = DEF_MAX_CLAUSES
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  cmd_t                           cmd,
	output sts_t                           sts,
	input  logic [LIT_W-1:0]               lit_in,
	input  logic                           last_in,
	input  logic                           cfg_we,
	input  logic [CFG_W-1:0]               cfg_data,
	output logic                           done,
	output logic [1:0]                     outcome,
	output logic [LIT_W-1:0]               str_lit,
	output logic [$clog2(MAX_CLAUSES)-1:0] idx,
	output logic                           full,
	output logic [CNT_W-1:0]               sub_cnt,
	output logic [CNT_W-1:0]               str_cnt
);

	localparam int IW  = $clog2(MAX_LITS);
	localparam int KW  = $clog2(MAX_LITS + 1);
	localparam int NW  = $clog2(MAX_LITS + 2);
	localparam int AW  = $clog2(MAX_CLAUSES);
	localparam int SW  = $clog2(MAX_CLAUSES + 1);
	localparam int LAW = $clog2(MAX_CLAUSES * MAX_LITS);
	localparam int XW  = $clog2(LIT_SPACE);

	logic [LIT_W-1:0] lits_mem  [MAX_CLAUSES*MAX_LITS];
	logic [KW-1:0]    len_mem   [MAX_CLAUSES];
	logic [LIT_W-1:0] watch_mem [MAX_CLAUSES];
	logic [SW-1:0]    wcnt_mem  [LIT_SPACE];

	logic [LIT_W-1:0] cur_q [MAX_LITS];
	logic [NW-1:0]    len_q, n_q, newlen, nm1;
	logic [SW-1:0]    stored_q, d_q;
	logic [IW-1:0]    i_q;
	logic [KW-1:0]    k_q;
	logic             neg_q, have_q;
	logic [LIT_W-1:0] slit_q, best_q;
	logic [SW-1:0]    bestc_q;
	logic [XW-1:0]    clr_q;
	logic [CFG_W-1:0] maxsz_q;

	logic [LIT_W-1:0] watch_rd_q, lit_rd_q;
	logic [KW-1:0]    len_rd_q;
	logic [SW-1:0]    wcnt_rd_q;

	logic [LIT_W-1:0] wl, nl;
	logic             pos_m, neg_m;
	logic [LAW-1:0]   rd_addr, wr_addr;

	assign newlen  = (int'(len_q) <= MAX_LITS) ? len_q + NW'(1) : len_q;
	assign nm1     = n_q - NW'(1);
	assign wl      = neg_q ? neg_lit(cur_q[i_q]) : cur_q[i_q];
	assign nl      = neg_lit(lit_rd_q);
	assign rd_addr = LAW'(d_q[AW-1:0]) * LAW'(MAX_LITS) + LAW'(k_q);
	assign wr_addr = LAW'(stored_q[AW-1:0]) * LAW'(MAX_LITS) + LAW'(k_q);

	// polarity of the stored literal in the current clause, last occurrence wins
	always_comb begin
		pos_m = 1'b0;
		neg_m = 1'b0;
		for (int j = 0; j < MAX_LITS; j++) begin
			if (NW'(j) < n_q) begin
				if (cur_q[j] == lit_rd_q) begin
					pos_m = 1'b1;
					neg_m = 1'b0;
				end else if (cur_q[j] == nl) begin
					pos_m = 1'b0;
					neg_m = 1'b1;
				end
			end
		end
	end

	assign sts.clr_done   = (clr_q == XW'(LIT_SPACE - 1));
	assign sts.too_large  = (int'(n_q) > MAX_LITS) || (int'(n_q) > int'(maxsz_q));
	assign sts.gt2        = (int'(n_q) > 2);
	assign sts.full       = (int'(stored_q) >= MAX_CLAUSES);
	assign sts.d_end      = (d_q == stored_q);
	assign sts.watch_last = neg_q && (NW'(i_q) == nm1);
	assign sts.watch_hit  = (watch_rd_q == wl);
	assign sts.k_end      = (k_q == len_rd_q);
	assign sts.tc_fail    = (!pos_m && !neg_m) || (neg_m && have_q);
	assign sts.best_done  = (NW'(i_q) == nm1);
	assign sts.wr_done    = (NW'(k_q) == nm1);

	// memories: registered reads, one write port each
	always_ff @(posedge clk) begin
		watch_rd_q <= watch_mem[d_q[AW-1:0]];
		len_rd_q   <= len_mem[d_q[AW-1:0]];
		lit_rd_q   <= lits_mem[rd_addr];
		wcnt_rd_q  <= wcnt_mem[cur_q[i_q]];
		if (cmd.wr_step) begin
			lits_mem[wr_addr] <= cur_q[k_q[IW-1:0]];
			if (sts.wr_done) begin
				len_mem[stored_q[AW-1:0]]   <= KW'(n_q);
				watch_mem[stored_q[AW-1:0]] <= best_q;
			end
		end
		if (cmd.clr_step) wcnt_mem[clr_q] <= '0;
		else if (cmd.wr_step && sts.wr_done) wcnt_mem[best_q] <= bestc_q + SW'(1);
	end

	always_ff @(posedge clk) begin
		if (cmd.push && int'(len_q) < MAX_LITS) cur_q[len_q[IW-1:0]] <= lit_in;
		if (cmd.push && last_in) n_q <= newlen;
		if (cmd.tc_step && neg_m) slit_q <= lit_rd_q;
		if (cmd.best_step && (i_q == '0 || wcnt_rd_q < bestc_q)) begin
			best_q  <= cur_q[i_q];
			bestc_q <= wcnt_rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			stored_q <= '0;
			d_q      <= '0;
			i_q      <= '0;
			k_q      <= '0;
			neg_q    <= 1'b0;
			have_q   <= 1'b0;
			clr_q    <= '0;
			maxsz_q  <= CFG_RESET;
			done     <= 1'b0;
			outcome  <= OUT_NONE;
			str_lit  <= '0;
			idx      <= '0;
			full     <= 1'b0;
			sub_cnt  <= '0;
			str_cnt  <= '0;
		end else begin
			done <= cmd.strobe;
			if (cfg_we) maxsz_q <= cfg_data;
			if (cmd.push) len_q <= last_in ? '0 : newlen;
			if (cmd.clr_init) begin
				clr_q    <= '0;
				stored_q <= '0;
			end
			if (cmd.clr_step) clr_q <= clr_q + XW'(1);
			if (cmd.res_clear || cmd.scan_init || cmd.too_large) begin
				outcome <= cmd.too_large ? OUT_TOO_LARGE : OUT_NONE;
				str_lit <= '0;
				idx     <= '0;
				full    <= 1'b0;
			end
			if (cmd.scan_init) begin
				i_q   <= '0;
				neg_q <= 1'b0;
				d_q   <= '0;
			end
			if (cmd.adv_watch) begin
				d_q <= '0;
				if (NW'(i_q) == nm1) begin
					i_q   <= '0;
					neg_q <= 1'b1;
				end else begin
					i_q <= i_q + IW'(1);
				end
			end
			if (cmd.d_inc) d_q <= d_q + SW'(1);
			if (cmd.tc_init) begin
				k_q    <= '0;
				have_q <= 1'b0;
			end
			if (cmd.tc_step) begin
				k_q <= k_q + KW'(1);
				if (neg_m) have_q <= 1'b1;
			end
			if (cmd.match) begin
				idx <= d_q[AW-1:0];
				if (have_q) begin
					outcome <= OUT_STRENGTHEN;
					str_lit <= slit_q;
					if (str_cnt != '1) str_cnt <= str_cnt + CNT_W'(1);
				end else begin
					outcome <= OUT_SUBSUMED;
					if (sub_cnt != '1) sub_cnt <= sub_cnt + CNT_W'(1);
				end
			end
			if (cmd.set_full) full <= 1'b1;
			if (cmd.best_init) begin
				i_q <= '0;
				k_q <= '0;
			end
			if (cmd.best_step) i_q <= i_q + IW'(1);
			if (cmd.wr_step) begin
				k_q <= k_q + KW'(1);
				if (sts.wr_done) stored_q <= stored_q + SW'(1);
			end
		end
	end

endmodule

// ===== sv/clause_forward_subsumption.sv =====
// Forward subsumption against a clause store, one watch literal per clause.
// Input: pulse start with op/literal/last while busy is low. op=0 pushes one
// literal of the current clause; last=1 ends the clause. op=1 clears the store
// and the watch counts (running totals and a partial clause are kept).
// Output: one item per finished clause, shown for a single cycle with done
// high; the receiver cannot stall it and must take it in that cycle.
// Config: cfg_valid/cfg_ready write max_clause_size; cfg_ready is always high.
// Flow: a push without last stays in idle. A finished clause of n literals
// passes one decide state. With more than two literals the check walks 2n watch
// literals, each through an address and a check state per stored clause, and
// each tested stored literal passes another address and check state (the
// deciding match is recorded in a last address state). A room check follows,
// an address and a check state per literal pick the watch and n literals are
// written to the store, then a result state; done rises the cycle after it.
// An oversized clause goes from decide straight to the result. Reset and clear
// sweep the 2048 watch counts, one per cycle; config writes are taken meanwhile.
module clause_forward_subsumption import cfs_pkg::*; #(
	parameter int MAX_LITS    = DEF_MAX_LITS,
	parameter int MAX_CLAUSES = DEF_MAX_CLAUSES
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic                           op,
	input  logic signed [LIT_W-1:0]        literal,
	input  logic                           last,
	output logic                           done,
	output logic [1:0]                     outcome,
	output logic signed [LIT_W-1:0]        strengthen_literal,
	output logic [$clog2(MAX_CLAUSES)-1:0] matched_index,
	output logic                           store_full,
	output logic [CNT_W-1:0]               subsumed_count,
	output logic [CNT_W-1:0]               strengthened_count,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [CFG_W-1:0]               cfg_data
);

	cmd_t             cmd;
	sts_t             sts;
	logic [LIT_W-1:0] str_lit;

	// register is always writable
	assign cfg_ready = 1'b1;

	// sequence the scan, selection and store write
	cfs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.last   (last),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// hold the clause, the store memories and the result registers
	cfs_dp #(
		.MAX_LITS    (MAX_LITS),
		.MAX_CLAUSES (MAX_CLAUSES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.lit_in   (literal),
		.last_in  (last),
		.cfg_we   (cfg_valid & cfg_ready),
		.cfg_data (cfg_data),
		.done     (done),
		.outcome  (outcome),
		.str_lit  (str_lit),
		.idx      (matched_index),
		.full     (store_full),
		.sub_cnt  (subsumed_count),
		.str_cnt  (strengthened_count)
	);

	assign strengthen_literal = str_lit;

	// a result always returns the block to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("busy after result");

	// oversized clauses carry no match and no full flag
	a_too_large: assert property (@(posedge clk) disable iff (!arst_n)
		(done && outcome == OUT_TOO_LARGE) |-> (matched_index == '0 && !store_full))
		else $error("too large result carries match data");

	// the strengthening literal is only reported with that outcome
	a_str_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && outcome != OUT_STRENGTHEN) |-> (strengthen_literal == '0))
		else $error("stray strengthening literal");

endmodule
